>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`endif

`ifndef SYNTH
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hw/rtl/fau_pkg.sv
// ---------------------------------------------------------------------------
// Fraction arithmetic unit package
// Widths, operation codes, state encoding and shared structs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fau_pkg;

    localparam int OPERAND_WIDTH = 31;
    localparam int FIELD_W       = 31;
    localparam int RES_W         = 63;
    localparam int KIND_W        = 3;
    localparam int CNT_W         = $clog2(OPERAND_WIDTH);

    localparam logic [KIND_W-1:0] KIND_NORM = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADD  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_MUL  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EQ   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NE   = 3'd4;

    typedef logic [OPERAND_WIDTH-1:0] opnd_t;
    typedef logic [RES_W-1:0]         wide_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        opnd_t             a_num;
        opnd_t             a_den;
        opnd_t             b_num;
        opnd_t             b_den;
    } req_t;

    typedef struct packed {
        wide_t num;
        wide_t den;
        logic  is_empty;
        logic  cmp;
    } res_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic borrow;
        logic zero;
    } alu_stat_t;

    typedef struct packed {
        logic idle;
        logic done;
    } core_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MLOAD,
        ST_MSTEP,
        ST_GCD,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

>>> hw/rtl/fau_if.sv
// ---------------------------------------------------------------------------
// Fraction arithmetic unit channels
// Valid/ready request and response channels with their payloads.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fau_req_if;
    logic                        valid;
    logic                        ready;
    logic [fau_pkg::KIND_W-1:0]  kind;
    logic [fau_pkg::FIELD_W-1:0] a_num;
    logic [fau_pkg::FIELD_W-1:0] a_den;
    logic [fau_pkg::FIELD_W-1:0] b_num;
    logic [fau_pkg::FIELD_W-1:0] b_den;

    modport source (output valid, kind, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, kind, a_num, a_den, b_num, b_den, output ready);
endinterface

interface fau_res_if;
    logic                      valid;
    logic                      ready;
    logic [fau_pkg::RES_W-1:0] res_num;
    logic [fau_pkg::RES_W-1:0] res_den;
    logic                      is_empty;
    logic                      compare_true;

    modport source (output valid, res_num, res_den, is_empty, compare_true, input ready);
    modport sink   (input valid, res_num, res_den, is_empty, compare_true, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/fraction_arithmetic_unit.sv
// ---------------------------------------------------------------------------
// Fraction arithmetic unit
// Normalize, add, multiply and compare of fractions, one request at a time.
// ---------------------------------------------------------------------------
// Usage:
//   req carries kind and two fractions a_num/a_den, b_num/b_den; rsp carries
//   res_num/res_den, is_empty and compare_true, one response per request.
//   A request is taken only while the sequencer is idle; req.ready drops for
//   the whole computation. All arithmetic runs on one shared 63-bit adder:
//     compare / unused kind : result set when the request is taken
//     multiply              : shift-add products an*bn, then ad*bd
//     add                   : shift-add products an*bd + ad*bn, then ad*bd
//     normalize             : binary GCD (one shift, subtract or swap per
//                             cycle), then restoring division of numerator
//                             and denominator by the odd gcd
//   Products stop early once the multiplier runs out of set bits.
//   The response sits in an output register; while it is full and rsp.ready
//   is low, a finished result waits in the sequencer and no new request is taken.
//   Reset clears the sequencer and the response valid flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module fraction_arithmetic_unit (
    input  wire               clk,
    input  wire               rst_n,
    fau_req_if.sink           req,
    fau_res_if.source         rsp
);

    localparam int OPW = fau_pkg::OPERAND_WIDTH;

    fau_pkg::req_t       req_d;
    fau_pkg::res_t       core_res;
    fau_pkg::core_stat_t core_stat;
    logic                start;
    logic                load;

    logic           rsp_valid_reg, rsp_valid_next;
    fau_pkg::wide_t rsp_num_reg, rsp_den_reg;
    logic           rsp_empty_reg, rsp_cmp_reg;

    // operands are taken modulo 2^OPERAND_WIDTH
    assign req_d.kind  = req.kind;
    assign req_d.a_num = req.a_num[OPW-1:0];
    assign req_d.a_den = req.a_den[OPW-1:0];
    assign req_d.b_num = req.b_num[OPW-1:0];
    assign req_d.b_den = req.b_den[OPW-1:0];

    assign req.ready = core_stat.idle;
    assign start     = req.valid && core_stat.idle;
    assign load      = core_stat.done && (!rsp_valid_reg || rsp.ready);

    fau_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req_d (req_d),
        .take  (load),
        .res   (core_res),
        .stat  (core_stat)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (load)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_num_reg   <= core_res.num;
            rsp_den_reg   <= core_res.den;
            rsp_empty_reg <= core_res.is_empty;
            rsp_cmp_reg   <= core_res.cmp;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.res_num      = rsp_num_reg;
    assign rsp.res_den      = rsp_den_reg;
    assign rsp.is_empty     = rsp_empty_reg;
    assign rsp.compare_true = rsp_cmp_reg;

    `ASSERT_NEXT(a_busy_after_req, clk, rst_n, req.valid && req.ready, !req.ready)
    `ASSERT_IMPLY(a_empty_is_zero, clk, rst_n, rsp.valid && rsp.is_empty, rsp.res_num == '0 && rsp.res_den == '0)
    `ASSERT_IMPLY(a_cmp_no_frac, clk, rst_n, rsp.valid && rsp.compare_true, rsp.res_num == '0 && rsp.res_den == '0 && !rsp.is_empty)

endmodule

`default_nettype wire

>>> hw/rtl/fau_alu.sv
// ---------------------------------------------------------------------------
// Fraction arithmetic unit shared adder
// One wide add/subtract with borrow and zero flags, used by the product, GCD and division steps.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fau_alu (
    input  fau_pkg::wide_t     a,
    input  fau_pkg::wide_t     b,
    input  fau_pkg::alu_op_t   op,
    output fau_pkg::wide_t     sum,
    output fau_pkg::alu_stat_t stat
);

    logic                    sub;
    logic [fau_pkg::RES_W:0] total;
    fau_pkg::wide_t          b_eff;

    assign sub   = (op == fau_pkg::ALU_SUB);
    assign b_eff = sub ? ~b : b;
    assign total = {1'b0, a} + {1'b0, b_eff} + {{fau_pkg::RES_W{1'b0}}, sub};

    assign sum         = total[fau_pkg::RES_W-1:0];
    assign stat.borrow = sub && !total[fau_pkg::RES_W];
    assign stat.zero   = (total[fau_pkg::RES_W-1:0] == '0);

endmodule

`default_nettype wire

>>> hw/rtl/fau_core.sv
// ---------------------------------------------------------------------------
// Fraction arithmetic unit sequencer
// Shift-add products, binary GCD and restoring division on the shared adder.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fau_core (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    input  fau_pkg::req_t        req_d,
    input  wire                  take,
    output fau_pkg::res_t        res,
    output fau_pkg::core_stat_t  stat
);

    localparam int OPW = fau_pkg::OPERAND_WIDTH;
    localparam int RW  = fau_pkg::RES_W;

    fau_pkg::state_t state_reg, state_next;

    logic [fau_pkg::KIND_W-1:0] kind_reg, kind_next;
    fau_pkg::opnd_t an_reg, an_next, ad_reg, ad_next, bn_reg, bn_next, bd_reg, bd_next;
    fau_pkg::wide_t num_reg, num_next, den_reg, den_next, mcand_reg, mcand_next;
    fau_pkg::opnd_t mplier_reg, mplier_next;
    fau_pkg::opnd_t x_reg, x_next, y_reg, y_next, rem_reg, rem_next;
    logic [fau_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0] pidx_reg, pidx_next;
    logic       div_den_reg, div_den_next;
    logic       cmp_reg, cmp_next;

    fau_pkg::wide_t     alu_a, alu_b, alu_sum;
    fau_pkg::alu_op_t   alu_op;
    fau_pkg::alu_stat_t alu_stat;

    logic           last_prod;
    fau_pkg::opnd_t op1, op2, dvd, dvd_new;
    logic [OPW:0]   shifted;
    logic           qbit;
    logic           a_void, b_void;

    fau_alu u_alu (
        .a    (alu_a),
        .b    (alu_b),
        .op   (alu_op),
        .sum  (alu_sum),
        .stat (alu_stat)
    );

    // product schedule: add = an*bd + ad*bn over ad*bd, mul = an*bn over ad*bd
    always_comb
    begin
        last_prod = (kind_reg == fau_pkg::KIND_ADD) ? (pidx_reg == 2'd2) : (pidx_reg == 2'd1);
        case (pidx_reg)
            2'd0:
            begin
                op1 = an_reg;
                op2 = (kind_reg == fau_pkg::KIND_ADD) ? bd_reg : bn_reg;
            end
            2'd1:
            begin
                op1 = ad_reg;
                op2 = (kind_reg == fau_pkg::KIND_ADD) ? bn_reg : bd_reg;
            end
            default:
            begin
                op1 = ad_reg;
                op2 = bd_reg;
            end
        endcase
    end

    assign dvd     = div_den_reg ? den_reg[OPW-1:0] : num_reg[OPW-1:0];
    assign shifted = {rem_reg, dvd[OPW-1]};
    assign qbit    = !alu_stat.borrow;
    assign dvd_new = {dvd[OPW-2:0], qbit};

    assign a_void = (req_d.a_num == '0) && (req_d.a_den == '0);
    assign b_void = (req_d.b_num == '0) && (req_d.b_den == '0);

    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        an_next      = an_reg;
        ad_next      = ad_reg;
        bn_next      = bn_reg;
        bd_next      = bd_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        mcand_next   = mcand_reg;
        mplier_next  = mplier_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        pidx_next    = pidx_reg;
        div_den_next = div_den_reg;
        cmp_next     = cmp_reg;
        alu_a        = '0;
        alu_b        = '0;
        alu_op       = fau_pkg::ALU_ADD;

        case (state_reg)
            fau_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    kind_next = req_d.kind;
                    an_next   = req_d.a_num;
                    ad_next   = req_d.a_den;
                    bn_next   = req_d.b_num;
                    bd_next   = req_d.b_den;
                    num_next  = '0;
                    den_next  = '0;
                    cmp_next  = 1'b0;
                    pidx_next = 2'd0;
                    state_next = fau_pkg::ST_DONE;
                    case (req_d.kind)
                        fau_pkg::KIND_NORM:
                        begin
                            if ((req_d.a_num != '0) && (req_d.a_den != '0))
                            begin
                                x_next     = req_d.a_num;
                                y_next     = req_d.a_den;
                                num_next   = {{(RW-OPW){1'b0}}, req_d.a_num};
                                den_next   = {{(RW-OPW){1'b0}}, req_d.a_den};
                                state_next = fau_pkg::ST_GCD;
                            end
                        end
                        fau_pkg::KIND_ADD, fau_pkg::KIND_MUL:
                        begin
                            if (!a_void && !b_void)
                                state_next = fau_pkg::ST_MLOAD;
                        end
                        fau_pkg::KIND_EQ:
                            cmp_next = !a_void && !b_void && (req_d.a_num == req_d.b_num)
                                       && (req_d.a_den == req_d.b_den);
                        fau_pkg::KIND_NE:
                            cmp_next = !a_void && !b_void && ((req_d.a_num != req_d.b_num)
                                       || (req_d.a_den != req_d.b_den));
                        default:
                            cmp_next = 1'b0;
                    endcase
                end
            end

            fau_pkg::ST_MLOAD:
            begin
                mcand_next  = {{(RW-OPW){1'b0}}, op1};
                mplier_next = op2;
                state_next  = fau_pkg::ST_MSTEP;
            end

            fau_pkg::ST_MSTEP:
            begin
                alu_a  = last_prod ? den_reg : num_reg;
                alu_b  = mcand_reg;
                alu_op = fau_pkg::ALU_ADD;
                if (mplier_reg == '0)
                begin
                    if (last_prod)
                        state_next = fau_pkg::ST_DONE;
                    else
                    begin
                        pidx_next  = pidx_reg + 2'd1;
                        state_next = fau_pkg::ST_MLOAD;
                    end
                end
                else
                begin
                    if (mplier_reg[0])
                    begin
                        if (last_prod)
                            den_next = alu_sum;
                        else
                            num_next = alu_sum;
                    end
                    mcand_next  = mcand_reg << 1;
                    mplier_next = mplier_reg >> 1;
                end
            end

            fau_pkg::ST_GCD:
            begin
                alu_a  = {{(RW-OPW){1'b0}}, x_reg};
                alu_b  = {{(RW-OPW){1'b0}}, y_reg};
                alu_op = fau_pkg::ALU_SUB;
                // common powers of two leave the operands as well as the gcd
                if (!x_reg[0] && !y_reg[0])
                begin
                    x_next   = x_reg >> 1;
                    y_next   = y_reg >> 1;
                    num_next = num_reg >> 1;
                    den_next = den_reg >> 1;
                end
                else if (!x_reg[0])
                    x_next = x_reg >> 1;
                else if (!y_reg[0])
                    y_next = y_reg >> 1;
                else if (alu_stat.zero)
                begin
                    cnt_next     = '0;
                    rem_next     = '0;
                    div_den_next = 1'b0;
                    state_next   = fau_pkg::ST_DIV;
                end
                else if (!alu_stat.borrow)
                    x_next = alu_sum[OPW-1:0];
                else
                begin
                    x_next = y_reg;
                    y_next = x_reg;
                end
            end

            fau_pkg::ST_DIV:
            begin
                // restoring division by the odd gcd held in x
                alu_a  = {{(RW-OPW-1){1'b0}}, shifted};
                alu_b  = {{(RW-OPW){1'b0}}, x_reg};
                alu_op = fau_pkg::ALU_SUB;
                rem_next = alu_stat.borrow ? shifted[OPW-1:0] : alu_sum[OPW-1:0];
                if (div_den_reg)
                    den_next = {{(RW-OPW){1'b0}}, dvd_new};
                else
                    num_next = {{(RW-OPW){1'b0}}, dvd_new};
                if (cnt_reg == fau_pkg::CNT_W'(OPW-1))
                begin
                    if (div_den_reg)
                        state_next = fau_pkg::ST_DONE;
                    else
                    begin
                        div_den_next = 1'b1;
                        cnt_next     = '0;
                        rem_next     = '0;
                    end
                end
                else
                    cnt_next = cnt_reg + fau_pkg::CNT_W'(1);
            end

            fau_pkg::ST_DONE:
            begin
                if (take)
                    state_next = fau_pkg::ST_IDLE;
            end

            default:
                state_next = fau_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= fau_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        an_reg      <= an_next;
        ad_reg      <= ad_next;
        bn_reg      <= bn_next;
        bd_reg      <= bd_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        pidx_reg    <= pidx_next;
        div_den_reg <= div_den_next;
        cmp_reg     <= cmp_next;
    end

    assign res.num      = num_reg;
    assign res.den      = den_reg;
    assign res.is_empty = (kind_reg inside {fau_pkg::KIND_NORM, fau_pkg::KIND_ADD,
                                            fau_pkg::KIND_MUL})
                          && (num_reg == '0) && (den_reg == '0);
    assign res.cmp      = cmp_reg;

    assign stat.idle = (state_reg == fau_pkg::ST_IDLE);
    assign stat.done = (state_reg == fau_pkg::ST_DONE);

endmodule

`default_nettype wire

>>> verif/fraction_arithmetic_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fraction arithmetic unit testbench
// Sends directed and random fraction requests over the request channel and
// checks every response against an in-bench predictor of normalize, add,
// multiply and compare. Both channels stall at random, except in the last random phase.
// ---------------------------------------------------------------------------

module fraction_arithmetic_unit_tb;

    import fau_pkg::*;

    localparam int   HALF_PERIOD  = 2;
    localparam int   RESET_CYCLES = 5;
    localparam int   STALL_LIMIT  = 20000;
    localparam int   TAIL_CYCLES  = 300;
    localparam int   PHASE_ITEMS  = 375;
    localparam opnd_t OPND_MAX    = {FIELD_W{1'b1}};

    // codes with no operation behind them
    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_MID = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    logic clk;
    logic rst_n;

    fau_req_if req_ch ();
    fau_res_if rsp_ch ();

    fraction_arithmetic_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    res_t expected_results[$];
    res_t front_result;
    int   error_count;
    int   sender_idle_pct;
    int   receiver_idle_pct;
    int   quiet_cycles;

    always
    begin
        clk = 1'b1;
        #HALF_PERIOD;
        clk = 1'b0;
        #HALF_PERIOD;
    end

    // -----------------------------------------------------------------------
    // Predictor
    // -----------------------------------------------------------------------
    function automatic longint unsigned common_divisor(input longint unsigned x,
                                                       input longint unsigned y);
        longint unsigned rem;
        while (y != 0)
        begin
            rem = x % y;
            x   = y;
            y   = rem;
        end
        return x;
    endfunction

    function automatic res_t predict_fraction(input logic [KIND_W-1:0] kind,
                                              input opnd_t an, input opnd_t ad,
                                              input opnd_t bn, input opnd_t bd);
        res_t            r;
        logic            a_void;
        logic            b_void;
        longint unsigned g;
        longint unsigned wn;
        longint unsigned wd;
        r      = '0;
        a_void = (an == 0) && (ad == 0);
        b_void = (bn == 0) && (bd == 0);
        wn     = 0;
        wd     = 0;
        case (kind)
            KIND_NORM:
            begin
                if (an != 0 && ad != 0)
                begin
                    g     = common_divisor(an, ad);
                    r.num = wide_t'(longint'(an) / g);
                    r.den = wide_t'(longint'(ad) / g);
                end
                else
                    r.is_empty = 1'b1;
            end
            KIND_ADD, KIND_MUL:
            begin
                if (!a_void && !b_void)
                begin
                    if (kind == KIND_ADD)
                        wn = longint'(an) * longint'(bd) + longint'(ad) * longint'(bn);
                    else
                        wn = longint'(an) * longint'(bn);
                    wd = longint'(ad) * longint'(bd);
                end
                r.num      = wide_t'(wn);
                r.den      = wide_t'(wd);
                r.is_empty = (wn == 0) && (wd == 0);
            end
            KIND_EQ:
                r.cmp = !a_void && !b_void && an == bn && ad == bd;
            KIND_NE:
                r.cmp = !a_void && !b_void && (an != bn || ad != bd);
            default:
                r = '0;
        endcase
        return r;
    endfunction

    // -----------------------------------------------------------------------
    // Request driver
    // -----------------------------------------------------------------------
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input opnd_t an, input opnd_t ad,
                                input opnd_t bn, input opnd_t bd);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind  <= kind;
        req_ch.a_num <= an;
        req_ch.a_den <= ad;
        req_ch.b_num <= bn;
        req_ch.b_den <= bd;
        do
            @(posedge clk);
        while (!req_ch.ready);
        expected_results.push_back(predict_fraction(kind, an, ad, bn, bd));
    endtask

    // hold off new requests until every outstanding response is back
    task automatic drain_results();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // -----------------------------------------------------------------------
    // Receiver, checker and watchdog
    // -----------------------------------------------------------------------
    always @(negedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    task automatic report_field(input string name, input wide_t want, input wide_t got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("%0t ns: response with none outstanding, expected none actual %0h/%0h",
                         $time, rsp_ch.res_num, rsp_ch.res_den);
            end
            else
            begin
                front_result = expected_results.pop_front();
                report_field("res_num", front_result.num, rsp_ch.res_num);
                report_field("res_den", front_result.den, rsp_ch.res_den);
                report_field("is_empty", wide_t'(front_result.is_empty),
                             wide_t'(rsp_ch.is_empty));
                report_field("compare_true", wide_t'(front_result.cmp),
                             wide_t'(rsp_ch.compare_true));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------
    task automatic test_normalize();
        send_request(KIND_NORM, 0, 0, 5, 7);
        send_request(KIND_NORM, 0, 9, 0, 0);
        send_request(KIND_NORM, 9, 0, 0, 0);
        send_request(KIND_NORM, 1, 1, OPND_MAX, OPND_MAX);
        send_request(KIND_NORM, OPND_MAX, OPND_MAX, 0, 0);
        send_request(KIND_NORM, OPND_MAX, 1, 0, 0);
        send_request(KIND_NORM, 12, 18, 0, 0);
        send_request(KIND_NORM, opnd_t'(1) << 30, opnd_t'(3) << 28, 0, 0);
    endtask

    task automatic test_add();
        send_request(KIND_ADD, 0, 0, 3, 4);
        send_request(KIND_ADD, 3, 4, 0, 0);
        send_request(KIND_ADD, 0, 5, 0, 7);
        send_request(KIND_ADD, 5, 0, 3, 0);
        send_request(KIND_ADD, OPND_MAX, OPND_MAX, OPND_MAX, OPND_MAX);
    endtask

    task automatic test_multiply();
        send_request(KIND_MUL, 0, 3, 4, 0);
        send_request(KIND_MUL, 0, 0, 2, 3);
        send_request(KIND_MUL, OPND_MAX, OPND_MAX, OPND_MAX, OPND_MAX);
        send_request(KIND_MUL, 2, 3, 5, 7);
    endtask

    task automatic test_compare();
        send_request(KIND_EQ, 3, 4, 3, 4);
        send_request(KIND_EQ, 3, 4, 6, 8);
        send_request(KIND_EQ, 0, 0, 0, 0);
        send_request(KIND_NE, 3, 4, 3, 5);
        send_request(KIND_NE, OPND_MAX, 1, OPND_MAX, 1);
        send_request(KIND_NE, 0, 0, 1, 1);
    endtask

    task automatic test_unused_kinds();
        send_request(KIND_SPARE_LO, OPND_MAX, OPND_MAX, OPND_MAX, OPND_MAX);
        send_request(KIND_SPARE_MID, 1, 2, 3, 4);
        send_request(KIND_SPARE_HI, OPND_MAX, 0, 0, OPND_MAX);
    endtask

    function automatic opnd_t random_operand();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return OPND_MAX;
            2:       return opnd_t'($urandom_range(1, 16));
            3:       return opnd_t'(1) << $urandom_range(0, FIELD_W - 1);
            default: return opnd_t'($urandom);
        endcase
    endfunction

    task automatic random_request();
        logic [KIND_W-1:0] kind;
        opnd_t             an;
        opnd_t             ad;
        opnd_t             bn;
        opnd_t             bd;
        int unsigned       pick;
        int unsigned       factor;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            kind = KIND_NORM;
        else if (pick < 50)
            kind = KIND_ADD;
        else if (pick < 70)
            kind = KIND_MUL;
        else if (pick < 83)
            kind = KIND_EQ;
        else if (pick < 96)
            kind = KIND_NE;
        else
            kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
        an = random_operand();
        ad = random_operand();
        bn = random_operand();
        bd = random_operand();
        // common factor so reduction has real work to do
        if (kind == KIND_NORM && $urandom_range(0, 1) == 1)
        begin
            factor = $urandom_range(1, 65535);
            an     = opnd_t'(factor * $urandom_range(1, 32767));
            ad     = opnd_t'(factor * $urandom_range(1, 32767));
        end
        if (kind == KIND_EQ || kind == KIND_NE)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    bn = an;
                    bd = ad;
                end
                1:       bn = an;
                2:       bd = ad;
                default: ;
            endcase
        end
        if ($urandom_range(0, 11) == 0)
        begin
            an = '0;
            ad = '0;
        end
        if ($urandom_range(0, 11) == 0)
        begin
            bn = '0;
            bd = '0;
        end
        send_request(kind, an, ad, bn, bd);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        sender_idle_pct   = send_pct;
        receiver_idle_pct = recv_pct;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            random_request();
            if (i == PHASE_ITEMS / 2)
                drain_results();
        end
        drain_results();
    endtask

    initial
    begin
        error_count       = 0;
        quiet_cycles      = 0;
        sender_idle_pct   = 24;
        receiver_idle_pct = 80;
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.kind       = KIND_NORM;
        req_ch.a_num      = '0;
        req_ch.a_den      = '0;
        req_ch.b_num      = '0;
        req_ch.b_den      = '0;
        rsp_ch.ready      = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_normalize();
        test_add();
        test_multiply();
        test_compare();
        test_unused_kinds();
        drain_results();
        test_random_traffic(24, 80);
        test_random_traffic(80, 24);
        test_random_traffic(0, 0);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            error_count++;
            $display("%0t ns: %0d responses missing, expected 0 actual %0d", $time,
                     expected_results.size(), expected_results.size());
        end
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
